### rtl/core/lsf_pkg.sv
`default_nettype none

package lsf_pkg;

	localparam int LSF_MAX_SAMPLES = 1024;
	localparam int LSF_SAMPLE_BITS = 16;
	localparam int LSF_FW          = 64;
	localparam int LSF_NUM_W       = 80;
	localparam int LSF_DEN_W       = 64;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_PREDICT = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_VAR = 2'd1;
	localparam logic [1:0] ST_CONST_Y  = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef enum logic [1:0] {
		DIV_MEAN,
		DIV_SLOPE,
		DIV_ISECT,
		DIV_R2
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     predict;
		logic     prod;
		logic     diff;
		logic     div_start;
		div_sel_t div_sel;
		logic     degen;
		logic     isect_mul;
		logic     pass_clr;
		logic     pass_rd;
		logic     out_fit;
		logic     clear_set;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic sxx_pos;
		logic pass_end;
		logic pipe_idle;
		logic r2_go;
	} sts_t;

endpackage

`default_nettype wire

### rtl/core/lsf_div.sv
`default_nettype none

module lsf_div import lsf_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [LSF_NUM_W-1:0] num,
	input  wire logic [LSF_DEN_W-1:0] den,
	output logic                      done,
	output logic      [LSF_NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(LSF_NUM_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [LSF_NUM_W-1:0] quo_q;
	logic [LSF_DEN_W-1:0] rem_q;
	logic [LSF_DEN_W-1:0] den_q;
	logic [LSF_DEN_W:0]   trial;
	logic                 ge;

	assign trial = {rem_q, quo_q[LSF_NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(LSF_NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[LSF_NUM_W-2:0], ge};
			rem_q <= ge ? LSF_DEN_W'(trial - {1'b0, den_q}) : LSF_DEN_W'(trial);
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

`default_nettype wire

### rtl/core/lsf_dp.sv
`default_nettype none

module lsf_dp import lsf_pkg::*; #(
	parameter int MAX_SAMPLES = LSF_MAX_SAMPLES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire cmd_t                              cmd,
	output sts_t                                   sts,
	input  wire logic signed [LSF_SAMPLE_BITS-1:0] x_value,
	input  wire logic signed [LSF_SAMPLE_BITS-1:0] y_value,
	output logic signed [31:0]                     slope,
	output logic signed [31:0]                     intercept,
	output logic        [16:0]                     r_squared,
	output logic signed [31:0]                     prediction,
	output logic        [1:0]                      status
);

	localparam int SB     = LSF_SAMPLE_BITS;
	localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = SB + CNT_W;
	localparam int PSUM_W = 2 * SB + CNT_W;
	localparam int FW     = LSF_FW;
	localparam int NUM_W  = LSF_NUM_W;
	localparam int DEN_W  = LSF_DEN_W;
	localparam int PR_W   = 32 + SB - 7;
	localparam int DY_W   = 34;
	localparam int D_W    = SB + 9;
	localparam int E_W    = 27;
	localparam logic [E_W-1:0] ERR_CAP = E_W'(64'd1 << 26);

	function automatic logic signed [31:0] sat_q32(input logic [NUM_W-1:0] q, input logic neg);
		logic signed [31:0] r;
		if (neg) begin
			r = (q >= NUM_W'(64'h8000_0000)) ? 32'sh8000_0000 : -$signed(q[31:0]);
		end else begin
			r = (q > NUM_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
		end
		return r;
	endfunction

	logic signed [SB-1:0] x_mem [MAX_SAMPLES];
	logic signed [SB-1:0] y_mem [MAX_SAMPLES];

	logic [CNT_W-1:0]         count_q;
	logic                     ovf_q;
	logic signed [SUM_W-1:0]  sum_x_q, sum_y_q;
	logic signed [PSUM_W-1:0] sum_xy_q, sum_xx_q;
	logic                     ld_s1;
	logic signed [SB-1:0]     x_s1, y_s1;
	logic signed [2*SB-1:0]   xy_s1, xx_s1;
	logic                     full;
	logic [CNT_W-1:0]         n_eff;

	logic signed [CNT_W+PSUM_W:0] nsxx_w, nsxy_w;
	logic signed [2*SUM_W-1:0]    sxsx_w, sxsy_w;
	logic signed [FW-1:0]         nsxx_q, sxsx_q, nsxy_q, sxsy_q, sxx_q, sxy_q;
	logic signed [31+SUM_W:0]     isp_w;
	logic signed [FW-1:0]         isp_q;
	logic                         sxx_pos;

	logic signed [31:0] fitted_slope_q, fitted_isect_q, mean_y_q;
	logic [16:0]        r2_q;
	div_sel_t           div_sel_q;
	logic               div_neg_q;

	logic [NUM_W-1:0]     div_num;
	logic [DEN_W-1:0]     div_den;
	logic                 div_neg;
	logic                 div_done;
	logic [NUM_W-1:0]     div_quot;
	logic [SUM_W-1:0]     sum_y_abs;
	logic [FW-1:0]        sxy_abs;
	logic signed [FW-1:0] sy_w, inum;
	logic [FW-1:0]        inum_abs;
	logic signed [31:0]   div_sat;

	logic [CNT_W-1:0]       idx_q, idx_nx;
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [SB-1:0]   xm_s1, ym_s1;
	logic signed [31+SB:0]  prod_s2;
	logic signed [SB+7:0]   yq_s2, yq_s3;
	logic signed [31+SB:0]  prod_w;
	logic signed [PR_W-1:0] pred_s3;
	logic signed [DY_W-1:0] dy_s3;
	logic signed [PR_W:0]   ey_w;
	logic [PR_W:0]          ey_abs;
	logic [DY_W-1:0]        dy_abs;
	logic [D_W-1:0]         d_s4;
	logic [E_W-1:0]         e_s4;
	logic [2*D_W-1:0]       dd_s5;
	logic [2*E_W-1:0]       ee_s5;
	logic [FW-1:0]          tss_q, rss_q;

	logic signed [31+SB:0]  pp_w;
	logic signed [PR_W-1:0] ps_w;
	logic signed [31:0]     pred_sat;
	logic [1:0]             fit_status;

	assign full  = count_q == CNT_W'(MAX_SAMPLES);
	assign n_eff = (count_q == '0) ? CNT_W'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xy_q <= '0;
			sum_xx_q <= '0;
			ld_s1    <= 1'b0;
		end else begin
			ld_s1 <= cmd.load && !full;
			if (cmd.clear_set) begin
				count_q  <= '0;
				ovf_q    <= 1'b0;
				sum_x_q  <= '0;
				sum_y_q  <= '0;
				sum_xy_q <= '0;
				sum_xx_q <= '0;
			end else begin
				if (cmd.load) begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
					end
				end
				if (ld_s1) begin
					sum_x_q  <= sum_x_q + SUM_W'(x_s1);
					sum_y_q  <= sum_y_q + SUM_W'(y_s1);
					sum_xy_q <= sum_xy_q + PSUM_W'(xy_s1);
					sum_xx_q <= sum_xx_q + PSUM_W'(xx_s1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			x_mem[count_q[ADDR_W-1:0]] <= x_value;
			y_mem[count_q[ADDR_W-1:0]] <= y_value;
		end
		if (cmd.pass_rd) begin
			xm_s1 <= x_mem[idx_q[ADDR_W-1:0]];
			ym_s1 <= y_mem[idx_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		x_s1  <= x_value;
		y_s1  <= y_value;
		xy_s1 <= x_value * y_value;
		xx_s1 <= x_value * x_value;
	end

	assign nsxx_w = $signed({1'b0, n_eff}) * sum_xx_q;
	assign nsxy_w = $signed({1'b0, n_eff}) * sum_xy_q;
	assign sxsx_w = sum_x_q * sum_x_q;
	assign sxsy_w = sum_x_q * sum_y_q;
	assign isp_w  = fitted_slope_q * sum_x_q;
	assign sxx_pos = !sxx_q[FW-1] && (sxx_q != '0);

	always_ff @(posedge clk) begin
		if (cmd.prod) begin
			nsxx_q <= FW'(nsxx_w);
			nsxy_q <= FW'(nsxy_w);
			sxsx_q <= FW'(sxsx_w);
			sxsy_q <= FW'(sxsy_w);
		end
		if (cmd.diff) begin
			sxx_q <= nsxx_q - sxsx_q;
			sxy_q <= nsxy_q - sxsy_q;
		end
		if (cmd.isect_mul) begin
			isp_q <= FW'(isp_w);
		end
	end

	always_comb begin
		sum_y_abs = sum_y_q[SUM_W-1] ? SUM_W'(-sum_y_q) : SUM_W'(sum_y_q);
		sxy_abs   = sxy_q[FW-1] ? FW'(-sxy_q) : FW'(sxy_q);
		sy_w      = FW'(sum_y_q);
		inum      = (sy_w <<< 16) - isp_q;
		inum_abs  = inum[FW-1] ? FW'(-inum) : FW'(inum);
		case (cmd.div_sel)
			DIV_MEAN: begin
				div_num = NUM_W'(sum_y_abs) << 8;
				div_den = DEN_W'(n_eff);
				div_neg = sum_y_q[SUM_W-1];
			end
			DIV_SLOPE: begin
				div_num = NUM_W'(sxy_abs) << 16;
				div_den = DEN_W'(sxx_q);
				div_neg = sxy_q[FW-1];
			end
			DIV_ISECT: begin
				div_num = NUM_W'(inum_abs);
				div_den = DEN_W'(n_eff) << 8;
				div_neg = inum[FW-1];
			end
			default: begin
				div_num = NUM_W'(tss_q - rss_q) << 16;
				div_den = DEN_W'(tss_q);
				div_neg = 1'b0;
			end
		endcase
	end

	lsf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign div_sat = sat_q32(div_quot, div_neg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fitted_slope_q <= '0;
			fitted_isect_q <= '0;
		end else if (cmd.degen) begin
			fitted_slope_q <= '0;
			fitted_isect_q <= mean_y_q;
		end else if (div_done && div_sel_q == DIV_SLOPE) begin
			fitted_slope_q <= div_sat;
		end else if (div_done && div_sel_q == DIV_ISECT) begin
			fitted_isect_q <= div_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_sel_q <= cmd.div_sel;
			div_neg_q <= div_neg;
		end
		if (cmd.prod) begin
			r2_q <= '0;
		end else if (div_done && div_sel_q == DIV_R2) begin
			r2_q <= (div_quot > NUM_W'(65536)) ? 17'd65536 : div_quot[16:0];
		end
		if (div_done && div_sel_q == DIV_MEAN) begin
			mean_y_q <= div_sat;
		end
	end

	assign idx_nx = idx_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
		end else begin
			if (cmd.pass_clr) begin
				idx_q <= '0;
			end else if (cmd.pass_rd) begin
				idx_q <= idx_nx;
			end
			v_s1 <= cmd.pass_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign prod_w = fitted_slope_q * xm_s1;
	assign ey_w   = (PR_W+1)'(yq_s3) - (PR_W+1)'(pred_s3);
	assign ey_abs = ey_w[PR_W] ? (PR_W+1)'(-ey_w) : (PR_W+1)'(ey_w);
	assign dy_abs = dy_s3[DY_W-1] ? DY_W'(-dy_s3) : DY_W'(dy_s3);

	always_ff @(posedge clk) begin
		prod_s2 <= prod_w;
		yq_s2   <= {ym_s1, 8'b0};
		pred_s3 <= PR_W'(prod_s2 >>> 8) + PR_W'(fitted_isect_q);
		dy_s3   <= DY_W'(yq_s2) - DY_W'(mean_y_q);
		yq_s3   <= yq_s2;
		d_s4    <= D_W'(dy_abs);
		e_s4    <= (ey_abs > (PR_W+1)'(ERR_CAP)) ? ERR_CAP : E_W'(ey_abs);
		dd_s5   <= d_s4 * d_s4;
		ee_s5   <= e_s4 * e_s4;
		if (cmd.pass_clr) begin
			tss_q <= '0;
			rss_q <= '0;
		end else if (v_s5) begin
			tss_q <= tss_q + FW'(dd_s5);
			rss_q <= rss_q + FW'(ee_s5);
		end
	end

	assign pp_w = fitted_slope_q * x_value;
	assign ps_w = PR_W'(pp_w >>> 8) + PR_W'(fitted_isect_q);

	always_comb begin
		if (ps_w[PR_W-1:31] != '0 && ps_w[PR_W-1:31] != '1) begin
			pred_sat = ps_w[PR_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			pred_sat = ps_w[31:0];
		end
		if (ovf_q) begin
			fit_status = ST_OVERFLOW;
		end else if (!sxx_pos) begin
			fit_status = ST_ZERO_VAR;
		end else if (tss_q == '0) begin
			fit_status = ST_CONST_Y;
		end else begin
			fit_status = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.predict) begin
			slope      <= fitted_slope_q;
			intercept  <= fitted_isect_q;
			r_squared  <= '0;
			prediction <= pred_sat;
			status     <= ST_OK;
		end else if (cmd.out_fit) begin
			slope      <= fitted_slope_q;
			intercept  <= fitted_isect_q;
			r_squared  <= r2_q;
			prediction <= '0;
			status     <= fit_status;
		end
	end

	assign sts.div_done  = div_done;
	assign sts.sxx_pos   = sxx_pos;
	assign sts.pass_end  = idx_nx >= count_q;
	assign sts.pipe_idle = !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5);
	assign sts.r2_go     = (tss_q != '0) && (rss_q < tss_q);

endmodule

`default_nettype wire

### rtl/core/lsf_ctrl.sv
`default_nettype none

module lsf_ctrl import lsf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic operation,
	input  wire logic last_sample,
	input  wire logic out_stall,
	input  wire sts_t sts,
	output logic      in_stall,
	output logic      out_valid,
	output cmd_t      cmd
);

	typedef enum logic [17:0] {
		S_IDLE       = 18'h00001,
		S_DRAIN      = 18'h00002,
		S_PROD       = 18'h00004,
		S_DIFF       = 18'h00008,
		S_MEAN_GO    = 18'h00010,
		S_MEAN_WAIT  = 18'h00020,
		S_CHECK      = 18'h00040,
		S_SLOPE_GO   = 18'h00080,
		S_SLOPE_WAIT = 18'h00100,
		S_ISECT_MUL  = 18'h00200,
		S_ISECT_GO   = 18'h00400,
		S_ISECT_WAIT = 18'h00800,
		S_PASS_INIT  = 18'h01000,
		S_PASS       = 18'h02000,
		S_PASS_DRAIN = 18'h04000,
		S_R2_CHECK   = 18'h08000,
		S_R2_WAIT    = 18'h10000,
		S_DONE       = 18'h20000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   accept;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || (operation == OP_PREDICT && !slot_free);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (operation == OP_PREDICT) begin
						cmd.predict = 1'b1;
					end else begin
						cmd.load = 1'b1;
						if (last_sample) begin
							state_d = S_DRAIN;
						end
					end
				end
			end
			S_DRAIN: state_d = S_PROD;
			S_PROD: begin
				cmd.prod = 1'b1;
				state_d  = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_MEAN_GO;
			end
			S_MEAN_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_MEAN;
				state_d       = S_MEAN_WAIT;
			end
			S_MEAN_WAIT: begin
				if (sts.div_done) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.sxx_pos) begin
					state_d = S_SLOPE_GO;
				end else begin
					cmd.degen = 1'b1;
					state_d   = S_DONE;
				end
			end
			S_SLOPE_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SLOPE;
				state_d       = S_SLOPE_WAIT;
			end
			S_SLOPE_WAIT: begin
				if (sts.div_done) begin
					state_d = S_ISECT_MUL;
				end
			end
			S_ISECT_MUL: begin
				cmd.isect_mul = 1'b1;
				state_d       = S_ISECT_GO;
			end
			S_ISECT_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_ISECT;
				state_d       = S_ISECT_WAIT;
			end
			S_ISECT_WAIT: begin
				if (sts.div_done) begin
					state_d = S_PASS_INIT;
				end
			end
			S_PASS_INIT: begin
				cmd.pass_clr = 1'b1;
				state_d      = S_PASS;
			end
			S_PASS: begin
				cmd.pass_rd = 1'b1;
				if (sts.pass_end) begin
					state_d = S_PASS_DRAIN;
				end
			end
			S_PASS_DRAIN: begin
				if (sts.pipe_idle) begin
					state_d = S_R2_CHECK;
				end
			end
			S_R2_CHECK: begin
				if (sts.r2_go) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_R2;
					state_d       = S_R2_WAIT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_R2_WAIT: begin
				if (sts.div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.out_fit   = 1'b1;
					cmd.clear_set = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= (out_valid_q && out_stall) || cmd.predict || cmd.out_fit;
		end
	end

endmodule

`default_nettype wire

### rtl/core/least_squares_line_fit_top.sv
// Load beats are taken one per cycle while no fit is running; they produce no result.
// Predict: result registered the cycle after the beat is taken; one per cycle with no fit or out_stall.
// Fit (last sample): the result waits on up to four serial divisions (mean, slope, intercept,
// r-squared) and the r-squared pass over the samples; zero x variance: the mean division only.
// Reset clears control, sums, count and fitted values; the sample memory is not cleared.
`default_nettype none

module least_squares_line_fit_top import lsf_pkg::*; #(
	parameter int MAX_SAMPLES = LSF_MAX_SAMPLES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              operation,
	input  wire logic signed [LSF_SAMPLE_BITS-1:0] x_value,
	input  wire logic signed [LSF_SAMPLE_BITS-1:0] y_value,
	input  wire logic                              last_sample,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [31:0]                     slope,
	output logic signed [31:0]                     intercept,
	output logic        [16:0]                     r_squared,
	output logic signed [31:0]                     prediction,
	output logic        [1:0]                      status
);

	cmd_t cmd;
	sts_t sts;

	lsf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.operation   (operation),
		.last_sample (last_sample),
		.out_stall   (out_stall),
		.sts         (sts),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.cmd         (cmd)
	);

	lsf_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.x_value    (x_value),
		.y_value    (y_value),
		.slope      (slope),
		.intercept  (intercept),
		.r_squared  (r_squared),
		.prediction (prediction),
		.status     (status)
	);

	a_predict_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && operation == OP_PREDICT) |=> out_valid)
		else $error("predict beat gave no result");

	a_fit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && operation == OP_LOAD && last_sample) |=> in_stall)
		else $error("input taken during fit");

	a_r2_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (r_squared <= 17'd65536))
		else $error("r_squared out of range");

	a_r2_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_ZERO_VAR || status == ST_CONST_Y)) |-> (r_squared == '0))
		else $error("r_squared set with error status");

endmodule

`default_nettype wire
